@@ hdl/multi_policy_task_picker_unit_assert.svh @@
// assertion macros for the task picker checker
// no dependencies
`ifndef MULTI_POLICY_TASK_PICKER_UNIT_ASSERT_SVH
`define MULTI_POLICY_TASK_PICKER_UNIT_ASSERT_SVH

// condition implies consequence in the same cycle
`define MPTP_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// condition implies consequence in the next cycle
`define MPTP_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

@@ hdl/mptp_pkg.sv @@
// shared types and constants for the task picker
// no dependencies
package mptp_pkg;

  localparam int SLOTS_DEF = 64;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PICK  = 1'b1;

  localparam logic [1:0] POL_FIRST  = 2'd0;
  localparam logic [1:0] POL_OLDEST = 2'd1;
  localparam logic [1:0] POL_RATIO  = 2'd2;
  localparam logic [1:0] POL_MULTI  = 2'd3;

  localparam logic [2:0] ST_RUNNABLE = 3'd3;

  localparam logic [1:0] LVL_HIGH = 2'd0;
  localparam logic [1:0] LVL_MID  = 2'd1;
  localparam logic [1:0] LVL_LOW  = 2'd2;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN} state_t;

  typedef struct packed {
    logic        operation;
    logic [5:0]  slot;
    logic [2:0]  task_state;
    logic [15:0] task_id;
    logic [1:0]  level;
    logic [31:0] created_tick;
    logic [31:0] run_ticks;
    logic [31:0] last_run_tick;
    logic [31:0] now_tick;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [15:0] chosen_id;
    logic [5:0]  chosen_slot;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  task_state;
    logic [15:0] task_id;
    logic [1:0]  level;
    logic [31:0] created;
    logic [31:0] runtime;
    logic [31:0] last_run;
  } slot_rec_t;

  typedef struct packed {
    logic       clr;
    logic       vld;
    logic [1:0] pol;
  } scan_ctl_t;

endpackage

@@ hdl/mptp_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module mptp_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ hdl/mptp_eval.sv @@
// candidate evaluation and best tracking for one pick scan
// depends on mptp_pkg
module mptp_eval #(
  parameter int SLOTS = mptp_pkg::SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  mptp_pkg::scan_ctl_t      ctl,
  input  logic [$clog2(SLOTS)-1:0] idx1,
  input  mptp_pkg::slot_rec_t      rec,
  input  logic [31:0]              now,
  output logic                     pipe_busy,
  output logic                     found,
  output logic [15:0]              id,
  output logic [$clog2(SLOTS)-1:0] idx
);
  import mptp_pkg::*;
  localparam int AW = $clog2(SLOTS);

  logic run1;
  logic v2, v3;
  logic [AW-1:0] idx2, idx3;
  logic [15:0] id2, id3;
  logic run2, run3;
  logic [31:0] r2, r3;
  logic [32:0] d2, d3;
  logic [63:0] pn, pb;

  logic have, h0, h1, h2;
  logic [AW-1:0] pidx, i0, i1, i2;
  logic [15:0] pid, id0, id1, id2b;
  logic [31:0] pkey, key1;
  logic [31:0] best_r;
  logic [32:0] best_d;

  assign run1 = rec.task_state == ST_RUNNABLE;
  assign pipe_busy = v2 | v3;

  always_ff @(posedge clk) begin
    idx2 <= idx1;
    id2  <= rec.task_id;
    run2 <= run1;
    r2   <= rec.runtime;
    d2   <= {1'b0, now - rec.created} + 33'd1;
    idx3 <= idx2;
    id3  <= id2;
    run3 <= run2;
    r3   <= r2;
    d3   <= d2;
    pn   <= {32'd0, r2} * {31'd0, best_d};
    pb   <= {32'd0, best_r} * {31'd0, d2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      have <= 1'b0;
      h0 <= 1'b0;
      h1 <= 1'b0;
      h2 <= 1'b0;
    end else if (ctl.clr) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      have <= 1'b0;
      h0 <= 1'b0;
      h1 <= 1'b0;
      h2 <= 1'b0;
      best_d <= 33'd1;
      best_r <= 32'd0;
    end else begin
      v2 <= ctl.vld && ctl.pol == POL_RATIO;
      v3 <= v2;
      if (ctl.vld && run1) begin
        unique case (ctl.pol)
          POL_FIRST: begin
            if (!have) begin
              have <= 1'b1;
              pidx <= idx1;
              pid  <= rec.task_id;
            end
          end
          POL_OLDEST: begin
            if (!have || rec.last_run < pkey) begin
              have <= 1'b1;
              pidx <= idx1;
              pid  <= rec.task_id;
              pkey <= rec.last_run;
            end
          end
          POL_MULTI: begin
            if (rec.level == LVL_HIGH) begin
              h0 <= 1'b1;
              i0 <= idx1;
              id0 <= rec.task_id;
            end
            if (rec.level == LVL_MID && (!h1 || rec.last_run < key1)) begin
              h1 <= 1'b1;
              i1 <= idx1;
              id1 <= rec.task_id;
              key1 <= rec.last_run;
            end
            if (rec.level == LVL_LOW) begin
              h2 <= 1'b1;
              i2 <= idx1;
              id2b <= rec.task_id;
            end
          end
          POL_RATIO: begin
          end
        endcase
      end
      if (v3 && run3 && (!have || pn <= pb)) begin
        have <= 1'b1;
        pidx <= idx3;
        pid  <= id3;
        best_r <= r3;
        best_d <= d3;
      end
    end
  end

  always_comb begin
    found = 1'b0;
    id = '0;
    idx = '0;
    if (ctl.pol == POL_MULTI) begin
      priority if (h0) begin
        found = 1'b1;
        id = id0;
        idx = i0;
      end else if (h1) begin
        found = 1'b1;
        id = id1;
        idx = i1;
      end else if (h2) begin
        found = 1'b1;
        id = id2b;
        idx = i2;
      end
    end else if (have) begin
      found = 1'b1;
      id = pid;
      idx = pidx;
    end
  end
endmodule

@@ hdl/multi_policy_task_picker_unit.sv @@
// top level of the multi-policy task picker
// depends on mptp_pkg, mptp_ram, mptp_eval
//
// channel   direction  handshake
// req       in         start, busy
// rsp       out        done strobe, one cycle
// cfg       in         cfg_we, cfg_wdata
//
// a write word does not make the unit busy, its result appears the next cycle
// a pick makes one ram read per slot, with a pause after each read for least run ratio
// after reset a clearing pass that writes every slot to zero holds busy high
// results cannot be stalled
module multi_policy_task_picker_unit #(
  parameter int SLOTS = mptp_pkg::SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  mptp_pkg::in_word_t  req,
  output logic                done,
  output mptp_pkg::out_word_t rsp,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_wdata
);
  import mptp_pkg::*;
  localparam int AW = $clog2(SLOTS);
  localparam int IW = (AW + 1 > 7) ? AW + 1 : 7;

  state_t st, st_next;
  logic [AW:0] ia, ia_next;
  logic phase, phase_next;
  logic [1:0] policy;
  logic [31:0] now;
  logic v1;
  logic [AW-1:0] idx1;

  logic we, re, accept, wr_acc, pk_acc, wr_ok, scan_end;
  logic [AW-1:0] waddr;
  slot_rec_t wdata, rdata;
  logic [IW-1:0] slot_ext;
  scan_ctl_t ctl;
  logic pipe_busy, e_found;
  logic [15:0] e_id;
  logic [AW-1:0] e_idx;

  assign busy = st != S_IDLE;
  assign accept = start && !busy;
  assign wr_acc = accept && req.operation == OP_WRITE;
  assign pk_acc = accept && req.operation == OP_PICK;
  assign slot_ext = IW'(req.slot);
  assign wr_ok = slot_ext < IW'(SLOTS);

  always_comb begin
    st_next = st;
    ia_next = ia;
    phase_next = 1'b0;
    we = 1'b0;
    waddr = slot_ext[AW-1:0];
    wdata = '{task_state: req.task_state, task_id: req.task_id, level: req.level,
              created: req.created_tick, runtime: req.run_ticks,
              last_run: req.last_run_tick};
    re = 1'b0;
    scan_end = 1'b0;
    unique case (st)
      S_CLEAR: begin
        we = 1'b1;
        waddr = ia[AW-1:0];
        wdata = '0;
        ia_next = ia + 1'b1;
        if (ia == (AW+1)'(SLOTS - 1)) begin
          st_next = S_IDLE;
        end
      end
      S_IDLE: begin
        ia_next = '0;
        we = wr_acc && wr_ok;
        if (pk_acc) begin
          st_next = S_SCAN;
        end
      end
      S_SCAN: begin
        phase_next = (policy == POL_RATIO) ? ~phase : 1'b0;
        if (ia != (AW+1)'(SLOTS) && !phase) begin
          re = 1'b1;
          ia_next = ia + 1'b1;
        end
        if (ia == (AW+1)'(SLOTS) && !v1 && !pipe_busy) begin
          scan_end = 1'b1;
          st_next = S_IDLE;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_CLEAR;
      ia <= '0;
      phase <= 1'b0;
      v1 <= 1'b0;
      done <= 1'b0;
      policy <= POL_FIRST;
    end else begin
      st <= st_next;
      ia <= ia_next;
      phase <= phase_next;
      v1 <= re;
      done <= wr_acc || scan_end;
      if (cfg_we) begin
        policy <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx1 <= ia[AW-1:0];
    if (pk_acc) begin
      now <= req.now_tick;
    end
    if (scan_end) begin
      rsp.found <= e_found;
      rsp.chosen_id <= e_id;
      rsp.chosen_slot <= 6'(e_idx);
    end else begin
      rsp <= '0;
    end
  end

  assign ctl = '{clr: pk_acc, vld: v1, pol: policy};

  mptp_ram #(.W($bits(slot_rec_t)), .D(SLOTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(ia[AW-1:0]), .rdata(rdata)
  );

  mptp_eval #(.SLOTS(SLOTS)) u_eval (
    .clk(clk), .rst(rst), .ctl(ctl), .idx1(idx1), .rec(rdata), .now(now),
    .pipe_busy(pipe_busy), .found(e_found), .id(e_id), .idx(e_idx)
  );
endmodule

@@ hdl/mptp_checker.sv @@
// port level checks for the task picker, bound to the top level
// depends on mptp_pkg and multi_policy_task_picker_unit_assert.svh
`include "multi_policy_task_picker_unit_assert.svh"
module mptp_props (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input mptp_pkg::in_word_t  req,
  input logic                done,
  input mptp_pkg::out_word_t rsp
);
  import mptp_pkg::*;

  `MPTP_ASSERT_NXT(a_write_done, clk, rst, start && !busy && req.operation == OP_WRITE, done && !rsp.found)
  `MPTP_ASSERT_NXT(a_pick_busy, clk, rst, start && !busy && req.operation == OP_PICK, busy && !done)
  `MPTP_ASSERT_IMP(a_empty_zero, clk, rst, done && !rsp.found, rsp.chosen_id == 16'd0 && rsp.chosen_slot == 6'd0)
  `MPTP_ASSERT_IMP(a_no_idle_result, clk, rst, !done, !rsp.found)
endmodule

bind multi_policy_task_picker_unit mptp_props u_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done), .rsp(rsp)
);
